// ===== sv/dmti_pkg.sv =====
// shared types and constants for the display-mode table insert block
`default_nettype none

package dmti_pkg;

    // table size and derived widths
    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // descriptor field widths
    localparam int TAG_W    = 32;
    localparam int WIDTH_W  = 16;
    localparam int HEIGHT_W = 16;
    localparam int DEPTH_W  = 8;
    localparam int RATE_W   = 16;
    localparam int FLAGS_W  = 32;
    localparam int KEY_W    = WIDTH_W + HEIGHT_W + DEPTH_W + RATE_W;

    // stream widths
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 16;
    localparam int ECOUNT_W   = 7;

    // largest legal color depth
    localparam logic [DEPTH_W-1:0] MAX_COLOR_DEPTH = DEPTH_W'(32);

    // result codes
    typedef enum logic [1:0] {
        OUT_INSERTED  = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_INVALID   = 2'd2,
        OUT_FULL      = 2'd3
    } t_outcome;

    // search request travelling down the cell chain
    typedef struct packed {
        logic               valid;
        logic               hit;
        logic               placed;
        logic [CNT_W-1:0]   remain;
        logic [KEY_W-1:0]   key;
        logic [FLAGS_W-1:0] attr;
        logic [TAG_W-1:0]   label;
    } t_probe;

endpackage

`default_nettype wire

// ===== sv/dmti_cell.sv =====
// one table entry with its compare and capture logic, passes the request on
`default_nettype none

module dmti_cell (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire dmti_pkg::t_probe i_probe,
    output dmti_pkg::t_probe      o_probe
);

    logic [dmti_pkg::KEY_W-1:0]   r_key;
    logic [dmti_pkg::FLAGS_W-1:0] r_attr;
    logic [dmti_pkg::TAG_W-1:0]   r_label;
    dmti_pkg::t_probe             r_probe;
    dmti_pkg::t_probe             n_probe;
    logic                         w_live;
    logic                         w_match;
    logic                         w_take;

    // this entry is occupied while the request still has entries to visit
    assign w_live  = (i_probe.remain != '0);
    assign w_match = (r_key == i_probe.key) && (r_attr == i_probe.attr);
    // first free entry takes the descriptor if nothing earlier matched
    assign w_take  = i_probe.valid && !w_live && !i_probe.hit && !i_probe.placed;

    // next request state
    always_comb begin
        n_probe = i_probe;
        if (w_live) begin
            n_probe.remain = i_probe.remain - dmti_pkg::CNT_W'(1);
            if (w_match) begin
                n_probe.hit = 1'b1;
            end
        end else if (w_take) begin
            n_probe.placed = 1'b1;
        end
    end

    // request register, only the valid bit is control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.valid <= 1'b0;
        end else begin
            r_probe.valid <= n_probe.valid;
        end
        r_probe.hit    <= n_probe.hit;
        r_probe.placed <= n_probe.placed;
        r_probe.remain <= n_probe.remain;
        r_probe.key    <= n_probe.key;
        r_probe.attr   <= n_probe.attr;
        r_probe.label  <= n_probe.label;
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_key   <= i_probe.key;
            r_attr  <= i_probe.attr;
            r_label <= i_probe.label;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// ===== sv/dedup_mode_table_insert.sv =====
// top level: display-mode table with duplicate check, built as a cell chain
//
// Usage: one display-mode descriptor per request on the s_axis channel, one
// result per request on the m_axis channel. A descriptor with zero width,
// zero height, zero color depth or a depth above 32 is refused without a search.
// A valid descriptor enters a chain of TABLE_DEPTH cells, one entry each,
// and moves one cell per cycle; occupied cells compare it, the first free
// cell stores it if no match was seen. A valid descriptor passes every cell
// register, then the state moves to S_DONE, from which the result is loaded
// into the output register; an invalid one goes from S_IDLE straight to
// S_DONE. One request is in flight at a time, so a new request is taken the
// cycle after the result is loaded into the output register. The output
// register holds its result while m_axis_tready is low; a finished result
// then waits internally and s_axis_tready stays low. Reset (i_rst_n low,
// synchronous) holds s_axis_tready low, empties the table, clears the sticky
// overflow flag and drops any request in flight; stored entries need no
// clearing since only entries below the fill count are compared.
`default_nettype none

module dedup_mode_table_insert (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // mode_tag, pixel_width, pixel_height, color_depth, refresh_rate, mode_flags
    input  wire [119:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // accepted, outcome, entry_count, overflowed, zero fill
    output logic [15:0] m_axis_tdata
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SEARCH = 3'b010,
        S_DONE   = 3'b100
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [dmti_pkg::CNT_W-1:0]      r_count;
    logic [dmti_pkg::CNT_W-1:0]      n_count;
    logic                            r_ovf;
    logic                            n_ovf;
    logic                            r_pend_acc;
    logic                            n_pend_acc;
    dmti_pkg::t_outcome              r_pend_code;
    dmti_pkg::t_outcome              n_pend_code;
    logic                            r_m_valid;
    logic                            n_m_valid;
    logic [dmti_pkg::OUT_DATA_W-1:0] r_m_data;
    logic [dmti_pkg::OUT_DATA_W-1:0] n_m_data;

    logic [dmti_pkg::TAG_W-1:0]      w_tag;
    logic [dmti_pkg::WIDTH_W-1:0]    w_width;
    logic [dmti_pkg::HEIGHT_W-1:0]   w_height;
    logic [dmti_pkg::DEPTH_W-1:0]    w_depth;
    logic [dmti_pkg::RATE_W-1:0]     w_rate;
    logic [dmti_pkg::FLAGS_W-1:0]    w_flags;
    logic                            w_in_acc;
    logic                            w_fields_ok;
    logic                            w_out_free;
    logic [dmti_pkg::CNT_W+dmti_pkg::ECOUNT_W-1:0] w_count_ext;

    dmti_pkg::t_probe                w_head;
    dmti_pkg::t_probe                w_probe [0:dmti_pkg::TABLE_DEPTH];
    dmti_pkg::t_probe                w_exit;

    // input field unpacking
    assign w_tag    = s_axis_tdata[31:0];
    assign w_width  = s_axis_tdata[47:32];
    assign w_height = s_axis_tdata[63:48];
    assign w_depth  = s_axis_tdata[71:64];
    assign w_rate   = s_axis_tdata[87:72];
    assign w_flags  = s_axis_tdata[119:88];

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_fields_ok   = (w_width != '0) && (w_height != '0) && (w_depth != '0)
                           && (w_depth <= dmti_pkg::MAX_COLOR_DEPTH);
    assign w_out_free    = !r_m_valid || m_axis_tready;

    // request injected into the head of the chain
    always_comb begin
        w_head.valid  = w_in_acc && w_fields_ok;
        w_head.hit    = 1'b0;
        w_head.placed = 1'b0;
        w_head.remain = r_count;
        w_head.key    = {w_width, w_height, w_depth, w_rate};
        w_head.attr   = w_flags;
        w_head.label  = w_tag;
    end

    assign w_probe[0] = w_head;

    // cell chain
    for (genvar g = 0; g < dmti_pkg::TABLE_DEPTH; g++) begin : g_cell
        dmti_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    assign w_exit = w_probe[dmti_pkg::TABLE_DEPTH];

    // entry count widened; its low ECOUNT_W bits fill the result field
    assign w_count_ext = (dmti_pkg::CNT_W + dmti_pkg::ECOUNT_W)'(r_count);

    // control and result sequencing
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pend_acc  = r_pend_acc;
        n_pend_code = r_pend_code;
        n_m_valid   = r_m_valid;
        n_m_data    = r_m_data;
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (w_fields_ok) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_pend_acc  = 1'b0;
                        n_pend_code = dmti_pkg::OUT_INVALID;
                        n_state     = S_DONE;
                    end
                end
            end
            S_SEARCH: begin
                if (w_exit.valid) begin
                    n_state = S_DONE;
                    if (w_exit.hit) begin
                        n_pend_acc  = 1'b1;
                        n_pend_code = dmti_pkg::OUT_DUPLICATE;
                    end else if (w_exit.placed) begin
                        n_pend_acc  = 1'b1;
                        n_pend_code = dmti_pkg::OUT_INSERTED;
                        n_count     = r_count + dmti_pkg::CNT_W'(1);
                    end else begin
                        n_pend_acc  = 1'b0;
                        n_pend_code = dmti_pkg::OUT_FULL;
                        n_ovf       = 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {5'b0, r_ovf, w_count_ext[dmti_pkg::ECOUNT_W-1:0],
                                 r_pend_code, r_pend_acc};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_m_valid <= n_m_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_pend_acc  <= n_pend_acc;
        r_pend_code <= n_pend_code;
        r_m_data    <= n_m_data;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // fill count never passes the table size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= dmti_pkg::CNT_W'(dmti_pkg::TABLE_DEPTH))
        else $error("fill count above table size");

    // overflow flag is sticky
    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag cleared without reset");

    // fill count only grows by one
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> r_count == $past(r_count) + dmti_pkg::CNT_W'(1))
        else $error("fill count moved by other than one");

    // a request leaves the chain only while a search is open
    a_exit_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.valid |-> r_state == S_SEARCH)
        else $error("chain output outside search");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for the display-mode table insert block: directed rows, then random descriptors checked against a table predictor

module tb_top;

    import dmti_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 840;
    localparam int CALM_ITEMS   = 120;
    localparam int SEGMENT_LEN  = 50;
    localparam int DRAIN_CYCLES = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 400000;

    // request layout, last field in the lowest bits
    typedef struct packed {
        logic [FLAGS_W-1:0]  flags;
        logic [RATE_W-1:0]   rate;
        logic [DEPTH_W-1:0]  depth;
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
        logic [TAG_W-1:0]    tag;
    } t_mode_desc;

    // result layout, last field in the lowest bits
    typedef struct packed {
        logic [4:0]          pad;
        logic                overflowed;
        logic [ECOUNT_W-1:0] entry_count;
        t_outcome            outcome;
        logic                accepted;
    } t_mode_result;

    typedef struct {
        t_mode_desc   desc;
        bit           typed;
        t_mode_result want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [15:0]  m_axis_tdata;

    // mirror of the mode table
    logic [KEY_W-1:0]   mirror_key   [TABLE_DEPTH];
    logic [FLAGS_W-1:0] mirror_flags [TABLE_DEPTH];
    int                 mirror_count = 0;
    bit                 mirror_overflow = 1'b0;

    t_mode_result pending_results[$];
    t_mode_desc   stored_modes[$];
    int           error_count = 0;
    int           cycle_count = 0;
    bit           tx_idle_on = 1'b1;
    bit           rx_idle_on = 1'b1;

    dedup_mode_table_insert u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // mode_tag, pixel_width, pixel_height, color_depth, refresh_rate, mode_flags
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // accepted, outcome, entry_count, overflowed, zero fill
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // insert a descriptor into the mirror and work out the result
    function automatic t_mode_result mode_insert_outcome(input t_mode_desc d);
        t_mode_result     res;
        logic [KEY_W-1:0] key;
        res = '0;
        key = {d.width, d.height, d.depth, d.rate};
        if (d.width == '0 || d.height == '0 || d.depth == '0 || d.depth > MAX_COLOR_DEPTH) begin
            res.outcome = OUT_INVALID;
        end else begin
            res.outcome = OUT_INSERTED;
            for (int i = 0; i < mirror_count; i++) begin
                if (mirror_key[i] == key && mirror_flags[i] == d.flags) begin
                    res.outcome = OUT_DUPLICATE;
                    break;
                end
            end
            if (res.outcome == OUT_INSERTED && mirror_count >= TABLE_DEPTH) begin
                mirror_overflow = 1'b1;
                res.outcome = OUT_FULL;
            end else if (res.outcome == OUT_INSERTED) begin
                mirror_key[mirror_count]   = key;
                mirror_flags[mirror_count] = d.flags;
                mirror_count++;
            end
            res.accepted = (res.outcome == OUT_INSERTED || res.outcome == OUT_DUPLICATE);
        end
        res.entry_count = ECOUNT_W'(mirror_count);
        res.overflowed  = mirror_overflow;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    endtask

    // compare one result with the oldest expectation
    task automatic check_result(input t_mode_result got);
        t_mode_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with nothing pending", got, 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.outcome !== want.outcome)
            report_mismatch("outcome", got.outcome, want.outcome);
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
        if (got.overflowed !== want.overflowed)
            report_mismatch("overflowed", got.overflowed, want.overflowed);
        if (got.pad !== '0)
            report_mismatch("zero fill", got.pad, 0);
    endtask

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_result(m_axis_tdata);
    end

    // result side stalls in bursts
    initial begin
        forever begin
            @(negedge i_clk);
            if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one request, wait for it to be taken, then record the expectation
    task automatic send_mode(input t_mode_desc d, input bit typed, input t_mode_result want);
        t_mode_result predicted;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = mode_insert_outcome(d);
        pending_results.push_back(typed ? want : predicted);
        if (predicted.outcome == OUT_INSERTED)
            stored_modes.push_back(d);
    endtask

    function automatic t_mode_desc random_valid_mode();
        t_mode_desc d;
        d.tag    = $urandom;
        d.width  = WIDTH_W'($urandom_range(1, 65535));
        d.height = HEIGHT_W'($urandom_range(1, 65535));
        d.depth  = DEPTH_W'($urandom_range(1, 32));
        d.rate   = RATE_W'($urandom_range(0, 65535));
        d.flags  = $urandom;
        return d;
    endfunction

    // mostly repeats of stored modes, some near misses, new modes and broken ones
    function automatic t_mode_desc pick_random_mode();
        t_mode_desc d;
        int         sel;
        sel = $urandom_range(0, 99);
        d = random_valid_mode();
        if (sel < 12) begin
            case ($urandom_range(0, 3))
                0: d.width  = '0;
                1: d.height = '0;
                2: d.depth  = '0;
                default: d.depth = DEPTH_W'($urandom_range(33, 255));
            endcase
        end else if (sel >= 30 && stored_modes.size() != 0) begin
            d = stored_modes[$urandom_range(0, stored_modes.size() - 1)];
            d.tag = $urandom;
            // near miss: one compared bit differs
            if (sel < 45) begin
                case ($urandom_range(0, 4))
                    0: d.width  = d.width  ^ (WIDTH_W'(1)  << $urandom_range(0, WIDTH_W - 1));
                    1: d.height = d.height ^ (HEIGHT_W'(1) << $urandom_range(0, HEIGHT_W - 1));
                    2: d.depth  = d.depth  ^ (DEPTH_W'(1)  << $urandom_range(0, DEPTH_W - 1));
                    3: d.rate   = d.rate   ^ (RATE_W'(1)   << $urandom_range(0, RATE_W - 1));
                    default: d.flags = d.flags ^ (FLAGS_W'(1) << $urandom_range(0, FLAGS_W - 1));
                endcase
            end
        end
        return d;
    endfunction

    function automatic t_stim_row stim_row(input logic [31:0] tag, input logic [15:0] w,
                                           input logic [15:0] h, input logic [7:0] dep,
                                           input logic [15:0] rate, input logic [31:0] flags,
                                           input bit typed, input logic acc, input t_outcome oc,
                                           input int cnt, input logic ovf);
        t_stim_row row;
        row.desc = '{flags: flags, rate: rate, depth: dep, height: h, width: w, tag: tag};
        row.typed = typed;
        row.want = '0;
        row.want.accepted    = acc;
        row.want.outcome     = oc;
        row.want.entry_count = ECOUNT_W'(cnt);
        row.want.overflowed  = ovf;
        return row;
    endfunction

    // main sequence
    initial begin
        t_stim_row rows[$];

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // invalid fields, extremes, duplicates and near misses
        rows.push_back(stim_row(32'h1, 16'd0, 16'd480, 8'd24, 16'd60, 32'h0,
                                1'b1, 1'b0, OUT_INVALID, 0, 1'b0));
        rows.push_back(stim_row(32'h2, 16'd640, 16'd0, 8'd24, 16'd60, 32'h0,
                                1'b1, 1'b0, OUT_INVALID, 0, 1'b0));
        rows.push_back(stim_row(32'h3, 16'd640, 16'd480, 8'd0, 16'd60, 32'h0,
                                1'b1, 1'b0, OUT_INVALID, 0, 1'b0));
        rows.push_back(stim_row(32'h4, 16'd640, 16'd480, 8'd33, 16'd60, 32'h0,
                                1'b1, 1'b0, OUT_INVALID, 0, 1'b0));
        rows.push_back(stim_row(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b0, OUT_INVALID, 0, 1'b0));
        rows.push_back(stim_row(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'd32, 16'hFFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b1, OUT_INSERTED, 1, 1'b0));
        rows.push_back(stim_row(32'h0, 16'd1, 16'd1, 8'd1, 16'd0, 32'h0,
                                1'b1, 1'b1, OUT_INSERTED, 2, 1'b0));
        rows.push_back(stim_row(32'h0, 16'hFFFF, 16'hFFFF, 8'd32, 16'hFFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b1, OUT_DUPLICATE, 2, 1'b0));
        rows.push_back(stim_row(32'h5, 16'hFFFF, 16'hFFFF, 8'd32, 16'hFFFF, 32'hFFFF_FFFE,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'h6, 16'd1, 16'd1, 8'd1, 16'd1, 32'h0,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'hFFFF_FFFF, 16'd1, 16'd1, 8'd1, 16'd0, 32'h0,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'h7, 16'd0, 16'hFFFF, 8'd32, 16'hFFFF, 32'hFFFF_FFFF,
                                1'b1, 1'b0, OUT_INVALID, 4, 1'b0));
        rows.push_back(stim_row(32'h8, 16'hFFFF, 16'hFFFF, 8'd31, 16'hFFFF, 32'hFFFF_FFFF,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'h9, 16'd640, 16'd480, 8'd24, 16'd60, 32'h0,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'hA, 16'd640, 16'd480, 8'd24, 16'd60, 32'h1,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));
        rows.push_back(stim_row(32'hB, 16'd640, 16'd480, 8'd24, 16'd60, 32'h0,
                                1'b0, 1'b0, OUT_INSERTED, 0, 1'b0));

        foreach (rows[i])
            send_mode(rows[i].desc, rows[i].typed, rows[i].want);

        // random requests, idling switched per segment and off at the tail
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else if (i % SEGMENT_LEN == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_mode(pick_random_mode(), 1'b0, '0);
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
